// ----- src/rcsp_pkg.sv -----
// Shared types and codes for the RGB color spec parser.
// No dependencies; used by rcsp_char_unit, rcsp_scale_unit and the top level.
package rcsp_pkg;

	// Scaling rule / field width codes (digits per component minus one)
	localparam logic [1:0] SCL_X17 = 2'd0;  // one digit: times 17
	localparam logic [1:0] SCL_ID  = 2'd1;  // two digits: as is
	localparam logic [1:0] SCL_12  = 2'd2;  // three digits: times 255/4095
	localparam logic [1:0] SCL_16  = 2'd3;  // four digits: times 255/65535

	// Finished spec handed from the character stage to the scaling stage
	typedef struct packed {
		logic        ok;    // spec well formed
		logic [1:0]  fw;    // field width code for splitting raw
		logic [1:0]  scl;   // scaling rule code
		logic [47:0] raw;   // red, green, blue fields, red highest
	} snap_t;

endpackage

// ----- src/rcsp_char_unit.sv -----
// Character stage of the RGB color spec parser: input register, per-spec
// parse state and the snapshot register of a finished spec.
// Depends on rcsp_pkg.
module rcsp_char_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_mode,
	input  logic [7:0]           in_char,
	input  logic                 in_last,
	output logic                 snap_valid,
	input  logic                 snap_ready,
	output rcsp_pkg::snap_t      snap
);
	import rcsp_pkg::*;

	localparam logic [7:0] CH_SLASH = 8'h2F;

	// input register
	logic       v_s1;
	logic       mode_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// parse state
	logic        busy_q;
	logic        form_q;
	logic        err_q;
	logic [1:0]  idx_q;
	logic [3:0]  cnt_q;
	logic [2:0]  first_q;
	logic [15:0] comp_q [3];
	logic [47:0] nib_q;

	// next values
	logic        form_e, err_n;
	logic [1:0]  idx_n;
	logic [3:0]  cnt_n;
	logic [2:0]  first_n;
	logic [15:0] comp_n [3];
	logic [47:0] nib_n;
	logic        is_hex;
	logic [3:0]  dval;
	logic [1:0]  k;
	logic        ok_n;
	snap_t       snap_n;

	logic snap_free, consume;

	assign snap_free = !snap_valid || snap_ready;
	assign consume   = v_s1 && (!last_s1 || snap_free);
	assign in_ready  = !v_s1 || consume;

	// hex digit decode
	always_comb begin
		is_hex = 1'b0;
		dval   = 4'd0;
		if (char_s1 >= 8'h30 && char_s1 <= 8'h39) begin
			is_hex = 1'b1;
			dval   = char_s1[3:0];
		end else if ((char_s1 >= 8'h61 && char_s1 <= 8'h66) ||
				(char_s1 >= 8'h41 && char_s1 <= 8'h46)) begin
			is_hex = 1'b1;
			dval   = char_s1[3:0] + 4'd9;
		end
	end

	// state update for one character; a new spec starts from cleared state
	always_comb begin
		form_e  = busy_q ? form_q : mode_s1;
		err_n   = busy_q ? err_q : 1'b0;
		idx_n   = busy_q ? idx_q : 2'd0;
		cnt_n   = busy_q ? cnt_q : 4'd0;
		first_n = busy_q ? first_q : 3'd0;
		nib_n   = busy_q ? nib_q : 48'd0;
		for (int i = 0; i < 3; i++) begin
			comp_n[i] = busy_q ? comp_q[i] : 16'd0;
		end
		k = (idx_n > 2'd2) ? 2'd2 : idx_n;

		if (!form_e) begin
			if (char_s1 == CH_SLASH) begin
				if (cnt_n == 4'd0 || idx_n >= 2'd2) begin
					err_n = 1'b1;
				end else begin
					if (idx_n == 2'd0) begin
						first_n = cnt_n[2:0];
					end
					idx_n = idx_n + 2'd1;
					cnt_n = 4'd0;
				end
			end else if (is_hex) begin
				if (cnt_n >= 4'd4) begin
					err_n = 1'b1;
				end else begin
					comp_n[k] = {comp_n[k][11:0], dval};
					cnt_n     = cnt_n + 4'd1;
				end
			end else begin
				err_n = 1'b1;
			end
		end else begin
			if (is_hex) begin
				if (cnt_n >= 4'd12) begin
					err_n = 1'b1;
				end else begin
					nib_n = {nib_n[43:0], dval};
					cnt_n = cnt_n + 4'd1;
				end
			end else begin
				err_n = 1'b1;
			end
		end

		// end-of-spec checks and snapshot
		snap_n = '0;
		if (!form_e) begin
			ok_n       = !err_n && idx_n == 2'd2 && cnt_n != 4'd0 && first_n != 3'd0;
			snap_n.fw  = SCL_16;
			snap_n.scl = 2'(first_n - 3'd1);
			snap_n.raw = {comp_n[0], comp_n[1], comp_n[2]};
		end else begin
			ok_n       = !err_n && (cnt_n == 4'd3 || cnt_n == 4'd6 ||
					cnt_n == 4'd9 || cnt_n == 4'd12);
			case (cnt_n)
				4'd3:    snap_n.fw = SCL_X17;
				4'd6:    snap_n.fw = SCL_ID;
				4'd9:    snap_n.fw = SCL_12;
				default: snap_n.fw = SCL_16;
			endcase
			snap_n.scl = snap_n.fw;
			snap_n.raw = nib_n;
		end
		snap_n.ok = ok_n;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= in_mode;
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			form_q  <= 1'b0;
			err_q   <= 1'b0;
			idx_q   <= 2'd0;
			cnt_q   <= 4'd0;
			first_q <= 3'd0;
		end else if (consume) begin
			busy_q  <= !last_s1;
			form_q  <= form_e;
			err_q   <= err_n;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
			first_q <= first_n;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			nib_q <= nib_n;
			for (int i = 0; i < 3; i++) begin
				comp_q[i] <= comp_n[i];
			end
		end
	end

	// snapshot register of a finished spec
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid <= 1'b0;
		end else if (snap_free) begin
			snap_valid <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_free && v_s1 && last_s1) begin
			snap <= snap_n;
		end
	end

endmodule

// ----- src/rcsp_scale_unit.sv -----
// Scaling stage of the RGB color spec parser: splits the finished spec
// into components, scales each to 8 bits and holds the result register.
// Depends on rcsp_pkg.
module rcsp_scale_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 snap_valid,
	output logic                 snap_ready,
	input  rcsp_pkg::snap_t      snap,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_ok,
	output logic [23:0]          out_color
);
	import rcsp_pkg::*;

	// ceil(2^30 / 273): exact quotient for products below 2^21
	localparam logic [21:0] RECIP_273 = 22'd3933121;

	// scale one component to 8 bits by the selected rule
	function automatic logic [7:0] scale8(input logic [15:0] v, input logic [1:0] scl);
		logic [20:0] p;
		logic [42:0] prod;
		logic [7:0]  q0;
		logic [16:0] back;
		logic [7:0]  res;
		p    = {1'b0, v, 4'b0} + {5'b0, v};
		prod = 43'(p) * 43'(RECIP_273);
		q0   = v[15:8];
		back = {1'b0, q0, 8'b0} + {9'b0, q0};
		case (scl)
			SCL_X17: res = p[7:0];
			SCL_ID:  res = v[7:0];
			SCL_12:  res = prod[37:30];
			default: res = (back > {1'b0, v}) ? q0 - 8'd1 : q0;
		endcase
		return res;
	endfunction

	logic [15:0] r_v, g_v, b_v;
	logic [23:0] color_n;

	assign snap_ready = !out_valid || out_ready;

	// split the raw digits by field width
	always_comb begin
		case (snap.fw)
			SCL_X17: begin
				r_v = {12'd0, snap.raw[11:8]};
				g_v = {12'd0, snap.raw[7:4]};
				b_v = {12'd0, snap.raw[3:0]};
			end
			SCL_ID: begin
				r_v = {8'd0, snap.raw[23:16]};
				g_v = {8'd0, snap.raw[15:8]};
				b_v = {8'd0, snap.raw[7:0]};
			end
			SCL_12: begin
				r_v = {4'd0, snap.raw[35:24]};
				g_v = {4'd0, snap.raw[23:12]};
				b_v = {4'd0, snap.raw[11:0]};
			end
			default: begin
				r_v = snap.raw[47:32];
				g_v = snap.raw[31:16];
				b_v = snap.raw[15:0];
			end
		endcase
		color_n = snap.ok ?
			{scale8(r_v, snap.scl), scale8(g_v, snap.scl), scale8(b_v, snap.scl)} : 24'd0;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (snap_ready) begin
			out_valid <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			out_ok    <= snap.ok;
			out_color <= color_n;
		end
	end

endmodule

// ----- src/rgb_color_spec_parser_top.sv -----
// RGB color spec parser.
// The slave stream takes one spec character per request: tdata is the
// character, tuser the form (0 slash r/g/b, 1 hash), read on the first
// character of a spec only, and tlast marks the final character.
// The master stream gives one result per spec, on its last character:
// tdata is the 24-bit color (red 23..16, green 15..8, blue 7..0, zero
// when invalid) and tuser is the ok flag.
// After its last character is accepted, a result passes through the input,
// snapshot and output registers in turn. Throughput: one character per
// cycle while tready is high, set by the character stage.
// Reset clears all valid flags and the parse state; the next character
// after reset starts a new spec.
// When the receiver stalls, the finished result holds in the output
// register, a second finished spec waits in the snapshot register and
// characters that do not end a spec are still taken; tready drops only
// when another spec end arrives with both registers full.
// Depends on rcsp_pkg, rcsp_char_unit and rcsp_scale_unit.
module rgb_color_spec_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tuser,   // mode
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // color
	output logic        m_tuser    // ok
);
	import rcsp_pkg::*;

	logic  snap_valid, snap_ready;
	snap_t snap;

	rcsp_char_unit u_char (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_mode    (s_tuser),
		.in_char    (s_tdata),
		.in_last    (s_tlast),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	rcsp_scale_unit u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_ok     (m_tuser),
		.out_color  (m_tdata)
	);

endmodule

// ----- sim/rgb_color_spec_parser_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for rgb_color_spec_parser_top: directed spec table, then random specs.
// Depends on the RTL of the parser only; results are checked against a local parse predictor.
module rgb_color_spec_parser_top_tb;

	localparam logic       FORM_SLASH  = 1'b0;
	localparam logic       FORM_HASH   = 1'b1;
	localparam logic [7:0] SEP_CHAR    = 8'h2F;   // '/'
	localparam int         RAND_CHARS  = 500;
	localparam int         HOLD_CYCLES = 300;
	localparam int         TAIL_CYCLES = 8;
	localparam int         CYCLE_LIMIT = 200000;

	typedef struct {
		logic       ok;
		logic [23:0] color;
	} spec_result_t;

	typedef struct {
		logic        md;
		logic [7:0]  ch;
		logic        lst;
		logic        typed;
		logic        eok;
		logic [23:0] ecol;
	} char_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // char_code
	logic        s_tuser;    // mode
	logic        s_tlast;    // last
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // color
	logic        m_tuser;    // ok

	// Predictor copy of the parse state
	logic        spec_form;
	logic        spec_open;
	logic        spec_bad;
	logic [1:0]  comp_idx;
	logic [3:0]  ndig;
	logic [2:0]  first_len;
	logic [15:0] comp_val [0:2];
	logic [47:0] hash_acc;

	spec_result_t pending_colors[$];
	char_row_t    spec_table[$];
	logic [7:0]   spec_chars[$];

	int mismatch_cnt = 0;
	int cycle_cnt    = 0;
	int tx_idle_pct  = 34;
	int rx_idle_pct  = 34;
	int chars_sent   = 0;
	bit hold_req     = 0;

	rgb_color_spec_parser_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	function automatic logic hex_val(input logic [7:0] c, output logic [3:0] d);
		d = 4'd0;
		if (c >= "0" && c <= "9") begin
			d = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			d = 4'(c - "a" + 10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			d = 4'(c - "A" + 10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Scale a component by digit count, keep the low byte
	function automatic logic [7:0] scale8(input logic [15:0] v, input int unsigned len);
		logic [31:0] p;
		p = {16'd0, v} * 32'd255;
		case (len)
			1: p = p / 32'd15;
			2: p = {16'd0, v};
			3: p = p / 32'd4095;
			default: p = p / 32'd65535;
		endcase
		return p[7:0];
	endfunction

	function automatic void clear_spec();
		spec_form   = FORM_SLASH;
		spec_open   = 1'b0;
		spec_bad    = 1'b0;
		comp_idx    = 2'd0;
		ndig        = 4'd0;
		first_len   = 3'd0;
		comp_val[0] = 16'd0;
		comp_val[1] = 16'd0;
		comp_val[2] = 16'd0;
		hash_acc    = 48'd0;
	endfunction

	// One character through the parser; a result only on the last one
	task automatic parse_char(input logic md, input logic [7:0] ch, input logic lst,
			output logic got, output logic ok, output logic [23:0] color);
		logic [3:0]  d;
		logic        is_hex;
		int unsigned n;
		logic [47:0] fld;
		got   = 1'b0;
		ok    = 1'b0;
		color = 24'd0;
		if (!spec_open) begin
			clear_spec();
			spec_form = md;
			spec_open = 1'b1;
		end
		is_hex = hex_val(ch, d);
		if (spec_form == FORM_SLASH) begin
			if (ch == SEP_CHAR) begin
				if (ndig == 0 || comp_idx >= 2) begin
					spec_bad = 1'b1;
				end else begin
					if (comp_idx == 0)
						first_len = ndig[2:0];
					comp_idx++;
					ndig = 4'd0;
				end
			end else if (is_hex) begin
				if (ndig >= 4) begin
					spec_bad = 1'b1;
				end else begin
					comp_val[comp_idx] = {comp_val[comp_idx][11:0], d};
					ndig++;
				end
			end else begin
				spec_bad = 1'b1;
			end
		end else begin
			if (!is_hex || ndig >= 12)
				spec_bad = 1'b1;
			else begin
				hash_acc = {hash_acc[43:0], d};
				ndig++;
			end
		end
		if (lst) begin
			got = 1'b1;
			ok  = !spec_bad;
			if (spec_form == FORM_SLASH) begin
				if (comp_idx != 2 || ndig == 0 || first_len == 0)
					ok = 1'b0;
				if (ok)
					for (int i = 0; i < 3; i++)
						color = {color[15:0], scale8(comp_val[i], first_len)};
			end else begin
				if (ndig != 3 && ndig != 6 && ndig != 9 && ndig != 12)
					ok = 1'b0;
				if (ok) begin
					n = ndig / 3;
					for (int i = 0; i < 3; i++) begin
						fld = (hash_acc >> (4 * n * (2 - i))) & ((48'd1 << (4 * n)) - 48'd1);
						color = {color[15:0], scale8(fld[15:0], n)};
					end
				end
			end
			if (!ok)
				color = 24'd0;
			clear_spec();
		end
	endtask

	// Offer one character; entered and left at a falling edge
	task automatic send_char(input logic md, input logic [7:0] ch, input logic lst,
			input logic typed, input logic eok, input logic [23:0] ecol);
		logic         got;
		spec_result_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= md;
		s_tlast  <= lst;
		do
			@(posedge clk);
		while (!s_tready);
		parse_char(md, ch, lst, got, res.ok, res.color);
		if (got) begin
			if (typed) begin
				res.ok    = eok;
				res.color = ecol;
			end
			pending_colors.push_back(res);
		end
		chars_sent++;
		@(negedge clk);
	endtask

	function automatic void add_row(input logic md, input logic [7:0] ch, input logic lst,
			input logic typed, input logic eok, input logic [23:0] ecol);
		char_row_t r;
		r.md    = md;
		r.ch    = ch;
		r.lst   = lst;
		r.typed = typed;
		r.eok   = eok;
		r.ecol  = ecol;
		spec_table.push_back(r);
	endfunction

	// Whole spec as table rows; later characters carry the other form, which must be ignored
	function automatic void add_text(input string s, input logic md, input logic typed,
			input logic eok, input logic [23:0] ecol);
		for (int i = 0; i < s.len(); i++)
			add_row((i == 0) ? md : !md, s[i], i == s.len() - 1, typed, eok, ecol);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
	endfunction

	function automatic void add_hex(input int cnt);
		for (int i = 0; i < cnt; i++)
			spec_chars.push_back(hex_char(4'($urandom_range(15))));
	endfunction

	// Random spec: mostly well formed, the rest broken or noise
	task automatic gen_spec(output logic md);
		int kind;
		int sub;
		int len;
		int ncomp;
		int lens [0:3];
		int cnt;
		spec_chars.delete();
		kind = $urandom_range(99);
		sub  = $urandom_range(5);
		md   = FORM_SLASH;
		if (kind < 40 || (kind >= 75 && sub <= 2)) begin
			len   = $urandom_range(1, 4);
			ncomp = 3;
			for (int k = 0; k < 4; k++)
				lens[k] = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : len;
			if (kind >= 75) begin
				case (sub)
					0: lens[$urandom_range(2)] = $urandom_range(5, 6);
					1: ncomp = 4;
					default: lens[$urandom_range(2)] = 0;
				endcase
			end
			for (int k = 0; k < ncomp; k++) begin
				add_hex(lens[k]);
				if (k < ncomp - 1)
					spec_chars.push_back(SEP_CHAR);
			end
		end else if (kind < 75 || sub == 4) begin
			md = FORM_HASH;
			add_hex(3 * $urandom_range(1, 4));
			if (sub == 4 && kind >= 75)
				spec_chars[$urandom_range(spec_chars.size() - 1)] = 8'($urandom_range(255));
		end else if (sub == 3) begin
			md = FORM_HASH;
			do
				cnt = $urandom_range(1, 14);
			while (cnt % 3 == 0 && cnt <= 12);
			add_hex(cnt);
		end else begin
			md  = 1'($urandom_range(1));
			cnt = $urandom_range(1, 6);
			for (int i = 0; i < cnt; i++)
				spec_chars.push_back(8'($urandom_range(255)));
		end
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_colors.size() == 0) begin
				report($sformatf("unexpected result ok=%0b color=%06h", m_tuser, m_tdata));
			end else begin
				if (m_tuser !== pending_colors[0].ok)
					report($sformatf("ok %0b, expected %0b", m_tuser, pending_colors[0].ok));
				if (m_tdata !== pending_colors[0].color)
					report($sformatf("color %06h, expected %06h", m_tdata,
						pending_colors[0].color));
				void'(pending_colors.pop_front());
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stalls plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		logic md;
		int   spec_no;
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		arst_n   = 1'b0;
		clear_spec();
		spec_no = 0;

		// Directed specs
		add_text("F/0/a", FORM_SLASH, 1'b1, 1'b1, 24'hFF00AA);
		add_text("fFf", FORM_HASH, 1'b1, 1'b1, 24'hFFFFFF);
		add_row(FORM_SLASH, 8'hFF, 1'b1, 1'b1, 1'b0, 24'd0);     // non-hex, top code
		add_row(FORM_HASH, 8'h00, 1'b1, 1'b1, 1'b0, 24'd0);      // non-hex, zero code
		add_row(FORM_HASH, SEP_CHAR, 1'b1, 1'b1, 1'b0, 24'd0);   // separator in hash form
		add_text("9/8/", FORM_SLASH, 1'b1, 1'b0, 24'd0);          // empty last component
		add_text("A/BC/D", FORM_SLASH, 1'b0, 1'b0, 24'd0);        // mixed lengths

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (spec_table[i])
			send_char(spec_table[i].md, spec_table[i].ch, spec_table[i].lst,
				spec_table[i].typed, spec_table[i].eok, spec_table[i].ecol);

		// Random specs
		while (chars_sent < RAND_CHARS) begin
			spec_no++;
			if (spec_no == 20)
				hold_req = 1;
			tx_idle_pct = (spec_no >= 40 && spec_no < 60) ? 0 : 34;
			rx_idle_pct = tx_idle_pct;
			gen_spec(md);
			foreach (spec_chars[i])
				send_char((i == 0) ? md : 1'($urandom_range(1)), spec_chars[i],
					i == spec_chars.size() - 1, 1'b0, 1'b0, 24'd0);
		end
		s_tvalid <= 1'b0;

		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_colors.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
